[hw/rtl/sobel_em_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types, register indexes and constants for the RGB Sobel block.
// ----------------------------------------------------------------------------

package sobel_em_pkg;

	localparam int DEFAULT_MAX_WIDTH = 1024;

	localparam int FRAME_WIDTH_W  = 11;
	localparam int FRAME_HEIGHT_W = 16;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_INDEX_W    = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd1024;
	localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd1;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	localparam int CHAN_W   = 8;
	localparam int CHANNELS = 3;
	localparam int PIX_W    = CHAN_W * CHANNELS;
	localparam int WIN_TAPS = 9;

	// |g| <= 1020, so g*g fits 20 bits and gx*gx + gy*gy fits 21 bits
	localparam int GRAD_W = 10;
	localparam int SQ_W   = 20;
	localparam int SUM_W  = 21;

	// round(sqrt(s)) > 255 exactly when s > 255.5^2, i.e. s > 65280
	localparam logic [SUM_W-1:0]  SAT_LIMIT = 21'd65280;
	localparam logic [CHAN_W-1:0] MAG_MAX   = 8'd255;

	typedef struct packed {
		logic              action;
		logic [CHAN_W-1:0] in_red;
		logic [CHAN_W-1:0] in_green;
		logic [CHAN_W-1:0] in_blue;
	} sobel_em_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic              frame_end;
	} sobel_em_out_t;

	// 3x3 window, row-major, tap 0 = top left
	typedef logic [WIN_TAPS-1:0][PIX_W-1:0] sobel_em_win_t;

	typedef struct packed {
		logic start;
		logic ack;
	} sobel_em_mag_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} sobel_em_mag_sts_t;

	typedef enum logic [1:0] {
		MS_IDLE,
		MS_SUM,
		MS_ROOT,
		MS_DONE
	} sobel_em_mag_state_t;

	typedef enum logic [2:0] {
		TS_IDLE,
		TS_PX_WB,
		TS_DR_RD,
		TS_START,
		TS_WAIT
	} sobel_em_top_state_t;

endpackage

[hw/rtl/sobel_em_mag.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel magnitude unit
// Gradients and squares of one 3x3 RGB window, then a bit-pair integer
// square root per channel, rounded to nearest and clamped to 255.
// ----------------------------------------------------------------------------

module sobel_em_mag (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sobel_em_pkg::sobel_em_win_t      win,
	input  sobel_em_pkg::sobel_em_mag_ctl_t  ctl,
	output sobel_em_pkg::sobel_em_mag_sts_t  sts,
	output logic [sobel_em_pkg::CHANNELS-1:0][sobel_em_pkg::CHAN_W-1:0] mag
);

	localparam int ROOT_STEPS = sobel_em_pkg::CHAN_W;
	localparam int CNT_W      = $clog2(ROOT_STEPS);
	localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

	sobel_em_pkg::sobel_em_mag_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic sq_en, load_en, iter_en;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sobel_em_pkg::MS_IDLE: if (ctl.start) state_d = sobel_em_pkg::MS_SUM;
			sobel_em_pkg::MS_SUM:  state_d = sobel_em_pkg::MS_ROOT;
			sobel_em_pkg::MS_ROOT: if (cnt_q == ROOT_LAST) state_d = sobel_em_pkg::MS_DONE;
			sobel_em_pkg::MS_DONE: if (ctl.ack) state_d = sobel_em_pkg::MS_IDLE;
			default:               state_d = sobel_em_pkg::MS_IDLE;
		endcase
	end

	always_comb begin
		sq_en    = (state_q == sobel_em_pkg::MS_IDLE) && ctl.start;
		load_en  = (state_q == sobel_em_pkg::MS_SUM);
		iter_en  = (state_q == sobel_em_pkg::MS_ROOT);
		sts.idle = (state_q == sobel_em_pkg::MS_IDLE);
		sts.done = (state_q == sobel_em_pkg::MS_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sobel_em_pkg::MS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load_en) begin
				cnt_q <= '0;
			end else if (iter_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	for (genvar ch = 0; ch < sobel_em_pkg::CHANNELS; ch++) begin : g_lane
		logic [sobel_em_pkg::CHAN_W-1:0] a [sobel_em_pkg::WIN_TAPS];
		logic [sobel_em_pkg::GRAD_W-1:0] xp, xn, yp, yn, ax, ay;
		logic [sobel_em_pkg::SQ_W-1:0]   sqx_s1, sqy_s1;
		logic [sobel_em_pkg::SUM_W-1:0]  sum;
		logic [15:0] op_q;
		logic [8:0]  rem_q;
		logic [7:0]  root_q;
		logic        sat_q;
		logic [10:0] pre, trial, diff;
		logic        ge;

		always_comb begin
			for (int i = 0; i < sobel_em_pkg::WIN_TAPS; i++) begin
				a[i] = win[i][ch*sobel_em_pkg::CHAN_W +: sobel_em_pkg::CHAN_W];
			end
			// Gx = right column minus left column, middle row weighted 2
			xp = 10'(a[2]) + 10'({a[5], 1'b0}) + 10'(a[8]);
			xn = 10'(a[0]) + 10'({a[3], 1'b0}) + 10'(a[6]);
			// Gy = bottom row minus top row, middle column weighted 2
			yp = 10'(a[6]) + 10'({a[7], 1'b0}) + 10'(a[8]);
			yn = 10'(a[0]) + 10'({a[1], 1'b0}) + 10'(a[2]);
			ax = (xp >= xn) ? xp - xn : xn - xp;
			ay = (yp >= yn) ? yp - yn : yn - yp;
		end

		always_ff @(posedge clk) begin
			if (sq_en) begin
				sqx_s1 <= 20'(ax) * 20'(ax);
				sqy_s1 <= 20'(ay) * 20'(ay);
			end
		end

		assign sum = 21'(sqx_s1) + 21'(sqy_s1);

		// one root bit per cycle; rem_q ends as s - root^2
		assign pre   = {rem_q, op_q[15:14]};
		assign trial = {1'b0, root_q, 2'b01};
		assign ge    = (pre >= trial);
		assign diff  = pre - trial;

		always_ff @(posedge clk) begin
			if (load_en) begin
				op_q   <= sum[15:0];
				sat_q  <= (sum > sobel_em_pkg::SAT_LIMIT);
				rem_q  <= '0;
				root_q <= '0;
			end else if (iter_en) begin
				op_q   <= {op_q[13:0], 2'b00};
				rem_q  <= ge ? diff[8:0] : pre[8:0];
				root_q <= {root_q[6:0], ge};
			end
		end

		// round up when the remainder passes the root (no ties for integers)
		assign mag[ch] = sat_q ? sobel_em_pkg::MAG_MAX
			: root_q + 8'(rem_q > 9'(root_q));
	end

endmodule

[hw/rtl/sobel_edge_magnitude_rgb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// Streaming 3x3 Sobel gradient magnitude on 8-bit RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Pixels (action 0) enter in raster order for a frame of frame_width by
// frame_height; each channel gets round(sqrt(gx^2 + gy^2)) clamped to 255,
// with neighbours outside the frame taken as zero. The result for pixel
// (r,c) leaves when pixel (r+1,c+1) comes in, and the last pixel of a row
// also releases the row above's last column. Once the frame's last pixel is
// in, send one drain request (action 1) per column to flush the final row;
// frame_end marks the last drain result, after which a new frame starts.
// Pixels past the end of a frame and drains before it are taken and dropped.
// One request is worked on at a time: a pixel is written back, then each
// result it causes goes through the shared magnitude unit (square stage plus
// an 8-step root iteration) and waits for a free output register; a drain
// first makes three reads through the line memories' read port.
// The result sits in an output
// register, so a new request is taken while the last result awaits pickup.
// The line memories need no clearing: each entry is written before it is
// read within a frame. Write frame_width/frame_height only between frames.
// ----------------------------------------------------------------------------

module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH = sobel_em_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration
	input  logic                                    cfg_write,
	input  logic [sobel_em_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [sobel_em_pkg::CFG_DATA_W-1:0]     cfg_data,
	// request channel
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  sobel_em_pkg::sobel_em_in_t              in_data,
	// result channel
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output sobel_em_pkg::sobel_em_out_t             out_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = (AW + 1 > sobel_em_pkg::FRAME_WIDTH_W) ? AW + 1
		: sobel_em_pkg::FRAME_WIDTH_W;
	localparam int PW = sobel_em_pkg::PIX_W;
	localparam logic [1:0] DK_LAST = 2'd3;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [sobel_em_pkg::FRAME_WIDTH_W-1:0]  frame_width_q;
	logic [sobel_em_pkg::FRAME_HEIGHT_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sobel_em_pkg::FRAME_WIDTH_RST;
			frame_height_q <= sobel_em_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				sobel_em_pkg::REG_FRAME_WIDTH:
					frame_width_q <= cfg_data[sobel_em_pkg::FRAME_WIDTH_W-1:0];
				sobel_em_pkg::REG_FRAME_HEIGHT:
					frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective frame: width clamped to 1..MAX_WIDTH, height 0 acts as 1
	logic [WW-1:0] fw_ext, max_ext, fw_m1, max_m1;
	logic [AW-1:0] wlast;
	logic [15:0]   h_eff;
	logic          two_rows;

	always_comb begin
		fw_ext  = WW'(frame_width_q);
		max_ext = WW'(MAX_WIDTH);
		fw_m1   = fw_ext - WW'(1);
		max_m1  = max_ext - WW'(1);
		if (fw_ext == '0) begin
			wlast = '0;
		end else if (fw_ext > max_ext) begin
			wlast = max_m1[AW-1:0];
		end else begin
			wlast = fw_m1[AW-1:0];
		end
		h_eff    = (frame_height_q == '0) ? 16'd1 : frame_height_q;
		two_rows = (h_eff >= 16'd2);
	end

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	sobel_em_pkg::sobel_em_top_state_t state_q, state_d;

	logic [15:0]   input_row_q;
	logic [AW-1:0] input_col_q, drain_col_q;
	logic [PW-1:0] px_q;
	logic [1:0]    dk_q, dslot_s1;
	logic          dok_s1;
	logic          cur_shift_q, pend_shift_q, fe_q, drain_sel_q;
	logic          out_valid_q;
	sobel_em_pkg::sobel_em_out_t out_q;
	sobel_em_pkg::sobel_em_win_t window_q, dwin_q, win_shift, mag_win;

	logic [AW-1:0] col_clamp, drain_clamp, mem_addr, dr_addr;
	logic          rows_done, dr_ok, emit_a, emit_b, col_last, drain_last;
	logic          accept, mem_we, out_free, load;

	sobel_em_pkg::sobel_em_mag_ctl_t mag_ctl;
	sobel_em_pkg::sobel_em_mag_sts_t mag_sts;
	logic [sobel_em_pkg::CHANNELS-1:0][sobel_em_pkg::CHAN_W-1:0] mag_res;

	assign col_clamp   = (input_col_q > wlast) ? wlast : input_col_q;
	assign drain_clamp = (drain_col_q > wlast) ? wlast : drain_col_q;
	assign rows_done   = (input_row_q >= h_eff);
	assign col_last    = (col_clamp == wlast);
	assign drain_last  = (drain_clamp == wlast);
	assign emit_a      = (input_row_q != '0) && (col_clamp != '0);
	assign emit_b      = (input_row_q != '0) && col_last;
	assign out_free    = !out_valid_q || out_ready;

	// Drain neighbours: column d-1, d, d+1; out-of-frame columns read as zero
	always_comb begin
		case (dk_q)
			2'd0: begin
				dr_ok   = (drain_clamp != '0);
				dr_addr = dr_ok ? drain_clamp - AW'(1) : drain_clamp;
			end
			2'd1: begin
				dr_ok   = 1'b1;
				dr_addr = drain_clamp;
			end
			2'd2: begin
				dr_ok   = (drain_clamp < wlast);
				dr_addr = dr_ok ? drain_clamp + AW'(1) : drain_clamp;
			end
			default: begin
				dr_ok   = 1'b0;
				dr_addr = drain_clamp;
			end
		endcase
	end

	assign mem_addr = (state_q == sobel_em_pkg::TS_DR_RD) ? dr_addr : col_clamp;

	// ------------------------------------------------------------------
	// Line memories: one write and one registered read per cycle each
	// ------------------------------------------------------------------
	logic [PW-1:0] line_one_up_mem [MAX_WIDTH];
	logic [PW-1:0] line_two_up_mem [MAX_WIDTH];
	logic [PW-1:0] rd_one_q, rd_two_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_one_up_mem[col_clamp] <= px_q;
			line_two_up_mem[col_clamp] <= rd_one_q;
		end
		rd_one_q <= line_one_up_mem[mem_addr];
		rd_two_q <= line_two_up_mem[mem_addr];
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			sobel_em_pkg::TS_IDLE: begin
				if (in_valid) begin
					if (in_data.action == sobel_em_pkg::ACT_PIXEL && !rows_done) begin
						state_d = sobel_em_pkg::TS_PX_WB;
					end else if (in_data.action == sobel_em_pkg::ACT_DRAIN && rows_done) begin
						state_d = sobel_em_pkg::TS_DR_RD;
					end
				end
			end
			sobel_em_pkg::TS_PX_WB: begin
				state_d = (emit_a || emit_b) ? sobel_em_pkg::TS_START : sobel_em_pkg::TS_IDLE;
			end
			sobel_em_pkg::TS_DR_RD: begin
				if (dk_q == DK_LAST) state_d = sobel_em_pkg::TS_START;
			end
			sobel_em_pkg::TS_START: state_d = sobel_em_pkg::TS_WAIT;
			sobel_em_pkg::TS_WAIT: begin
				if (mag_sts.done && out_free) begin
					state_d = pend_shift_q ? sobel_em_pkg::TS_START : sobel_em_pkg::TS_IDLE;
				end
			end
			default: state_d = sobel_em_pkg::TS_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == sobel_em_pkg::TS_IDLE);
		mem_we        = (state_q == sobel_em_pkg::TS_PX_WB);
		mag_ctl.start = (state_q == sobel_em_pkg::TS_START);
		load          = (state_q == sobel_em_pkg::TS_WAIT) && mag_sts.done && out_free;
		mag_ctl.ack   = load;
	end

	assign accept = in_valid && in_ready;

	// Window with the right column dropped: row above's last column.
	// Drains use their own window so the pixel window carries on untouched.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_shift[r*3]     = window_q[r*3 + 1];
			win_shift[r*3 + 1] = window_q[r*3 + 2];
			win_shift[r*3 + 2] = '0;
		end
		mag_win = drain_sel_q ? dwin_q : (cur_shift_q ? win_shift : window_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sobel_em_pkg::TS_IDLE;
			input_row_q  <= '0;
			input_col_q  <= '0;
			drain_col_q  <= '0;
			dk_q         <= '0;
			dok_s1       <= 1'b0;
			dslot_s1     <= '0;
			cur_shift_q  <= 1'b0;
			pend_shift_q <= 1'b0;
			fe_q         <= 1'b0;
			drain_sel_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			window_q     <= '0;
			dwin_q       <= '0;
		end else begin
			state_q <= state_d;

			if (accept) begin
				dk_q <= '0;
			end else if (state_q == sobel_em_pkg::TS_DR_RD) begin
				dk_q <= dk_q + 2'd1;
			end

			// pixel write-back: window shift, emission plan, raster counters
			if (state_q == sobel_em_pkg::TS_PX_WB) begin
				for (int r = 0; r < 3; r++) begin
					window_q[r*3]     <= (col_clamp == '0) ? '0 : window_q[r*3 + 1];
					window_q[r*3 + 1] <= (col_clamp == '0) ? '0 : window_q[r*3 + 2];
				end
				window_q[2] <= (input_row_q >= 16'd2) ? rd_two_q : '0;
				window_q[5] <= (input_row_q != '0) ? rd_one_q : '0;
				window_q[8] <= px_q;
				cur_shift_q  <= !emit_a;
				pend_shift_q <= emit_a && emit_b;
				fe_q         <= 1'b0;
				drain_sel_q  <= 1'b0;
				if (col_last) begin
					input_col_q <= '0;
					input_row_q <= input_row_q + 16'd1;
				end else begin
					input_col_q <= col_clamp + AW'(1);
				end
			end

			// drain: gather three columns into the drain window, bottom row zero
			if (state_q == sobel_em_pkg::TS_DR_RD) begin
				dok_s1   <= dr_ok;
				dslot_s1 <= dk_q;
				if (dk_q != '0) begin
					dwin_q[4'(dslot_s1)]         <= (dok_s1 && two_rows) ? rd_two_q : '0;
					dwin_q[4'(dslot_s1) + 4'd3]  <= dok_s1 ? rd_one_q : '0;
					dwin_q[4'(dslot_s1) + 4'd6]  <= '0;
				end
				if (dk_q == DK_LAST) begin
					cur_shift_q  <= 1'b0;
					pend_shift_q <= 1'b0;
					drain_sel_q  <= 1'b1;
					fe_q         <= drain_last;
					if (drain_last) begin
						input_row_q <= '0;
						input_col_q <= '0;
						drain_col_q <= '0;
					end else begin
						drain_col_q <= drain_clamp + AW'(1);
					end
				end
			end

			if (load && pend_shift_q) begin
				cur_shift_q  <= 1'b1;
				pend_shift_q <= 1'b0;
			end

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= {in_data.in_red, in_data.in_green, in_data.in_blue};
		end
		if (load) begin
			out_q.out_red   <= mag_res[2];
			out_q.out_green <= mag_res[1];
			out_q.out_blue  <= mag_res[0];
			out_q.frame_end <= fe_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ------------------------------------------------------------------
	// Magnitude unit
	// ------------------------------------------------------------------
	sobel_em_mag u_mag (
		.clk    (clk),
		.arst_n (arst_n),
		.win    (mag_win),
		.ctl    (mag_ctl),
		.sts    (mag_sts),
		.mag    (mag_res)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mag_ctl.start |-> mag_sts.idle)
		else $error("magnitude unit started while busy");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> mag_sts.idle)
		else $error("request taken while a result is still being computed");

	a_frame_end_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(load && fe_q) |-> (input_row_q == '0 && input_col_q == '0 && drain_col_q == '0))
		else $error("frame end issued without counters returned to zero");

	a_drain_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sobel_em_pkg::TS_DR_RD && dk_q != DK_LAST) |-> (mem_addr <= wlast))
		else $error("drain read outside the frame width");

endmodule

[verif/sobel_edge_magnitude_rgb_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude RGB testbench
// Drives raster frames and drain requests into the Sobel block under several
// frame shapes and handshake pressures. Every accepted request is run through
// a cycle-free model of the line buffers and 3x3 window. Each result leaving
// the block is compared, field by field, with the oldest predicted magnitude.
// ----------------------------------------------------------------------------

module sobel_edge_magnitude_rgb_tb;
	import sobel_em_pkg::*;

	localparam int LINE_DEPTH      = DEFAULT_MAX_WIDTH;
	// margin after the last result so a silent pixel is done before a register write
	localparam int QUIET_CYCLES    = 48;
	// long receiver hold-off so the block backs up and stalls its input
	localparam int HOLD_CYCLES     = 400;
	// cycles with no handshake or register write before the run is declared hung
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int REPORT_CAP      = 200;

	// ------------------------------------------------------------------------
	// Edge magnitude scoreboard: line buffers, window and frame counters kept
	// in step with accepted requests; predicted results wait in a FIFO.
	// ------------------------------------------------------------------------
	class edge_scoreboard;
		logic [PIX_W-1:0]          row_above [LINE_DEPTH];
		logic [PIX_W-1:0]          row_two_above [LINE_DEPTH];
		sobel_em_win_t             win;
		int unsigned               row_idx;
		int unsigned               col_idx;
		int unsigned               flush_col;
		logic [FRAME_WIDTH_W-1:0]  width_reg;
		logic [FRAME_HEIGHT_W-1:0] height_reg;
		sobel_em_out_t             expected_q[$];
		int                        errors;
		int                        checked;

		function new();
			foreach (row_above[i]) begin
				row_above[i]     = '0;
				row_two_above[i] = '0;
			end
			win        = '0;
			row_idx    = 0;
			col_idx    = 0;
			flush_col  = 0;
			width_reg  = FRAME_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			errors     = 0;
			checked    = 0;
		endfunction

		// width 0 behaves as 1, anything past the line depth as the depth
		function int unsigned frame_cols();
			if (width_reg == 0)
				return 1;
			if (width_reg > LINE_DEPTH)
				return LINE_DEPTH;
			return width_reg;
		endfunction

		function int unsigned frame_rows();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_FRAME_WIDTH)
				width_reg = val[FRAME_WIDTH_W-1:0];
			else
				height_reg = val[FRAME_HEIGHT_W-1:0];
		endfunction

		// rounded root of gx^2 + gy^2 for one channel, saturated at 255
		function automatic logic [CHAN_W-1:0] edge_level(sobel_em_win_t w, int sh);
			int p[WIN_TAPS];
			int gx, gy, sum, lo, hi, mid, i;
			for (i = 0; i < WIN_TAPS; i++)
				p[i] = int'((w[i] >> sh) & 24'hFF);
			gx  = -p[0] + p[2] - 2 * p[3] + 2 * p[5] - p[6] + p[8];
			gy  = -p[0] - 2 * p[1] - p[2] + p[6] + 2 * p[7] + p[8];
			sum = gx * gx + gy * gy;
			// bisection: lo*lo <= sum < hi*hi
			lo = 0;
			hi = 2048;
			while (hi - lo > 1) begin
				mid = (lo + hi) / 2;
				if (mid * mid <= sum)
					lo = mid;
				else
					hi = mid;
			end
			if (sum - lo * lo > lo)
				lo++;
			return (lo > 255) ? 8'd255 : lo[CHAN_W-1:0];
		endfunction

		function void queue_result(sobel_em_win_t w, logic last);
			sobel_em_out_t res;
			res.out_red   = edge_level(w, 16);
			res.out_green = edge_level(w, 8);
			res.out_blue  = edge_level(w, 0);
			res.frame_end = last;
			expected_q.push_back(res);
		endfunction

		// returns results caused, or -1 when the block drops the request
		function int note_request(sobel_em_in_t req);
			int unsigned   cols, rows, c, d;
			int            x, k, r, prior_count;
			logic [PIX_W-1:0] px, top, mid;
			sobel_em_win_t t;
			cols        = frame_cols();
			rows        = frame_rows();
			prior_count = expected_q.size();
			if (req.action == ACT_PIXEL) begin
				if (row_idx >= rows)
					return -1;
				c   = (col_idx >= cols) ? cols - 1 : col_idx;
				px  = {req.in_red, req.in_green, req.in_blue};
				top = (row_idx >= 2) ? row_two_above[c] : '0;
				mid = (row_idx >= 1) ? row_above[c] : '0;
				row_two_above[c] = row_above[c];
				row_above[c]     = px;
				if (c == 0)
					win = '0;
				for (r = 0; r < 3; r++) begin
					win[r*3]   = win[r*3+1];
					win[r*3+1] = win[r*3+2];
				end
				win[2] = top;
				win[5] = mid;
				win[8] = px;
				if (row_idx >= 1) begin
					if (c >= 1)
						queue_result(win, 1'b0);
					// row end also releases the last column of the row above
					if (c == cols - 1) begin
						t = '0;
						for (r = 0; r < 3; r++) begin
							t[r*3]   = win[r*3+1];
							t[r*3+1] = win[r*3+2];
						end
						queue_result(t, 1'b0);
					end
				end
				if (c == cols - 1) begin
					col_idx = 0;
					row_idx++;
				end else begin
					col_idx = c + 1;
				end
			end else begin
				if (row_idx < rows)
					return -1;
				d = (flush_col >= cols) ? cols - 1 : flush_col;
				t = '0;
				for (k = 0; k < 3; k++) begin
					x = int'(d) + k;
					if (x >= 1 && x - 1 < int'(cols)) begin
						t[k]   = (rows >= 2) ? row_two_above[x-1] : '0;
						t[3+k] = row_above[x-1];
					end
				end
				queue_result(t, d == cols - 1);
				if (d == cols - 1) begin
					row_idx   = 0;
					col_idx   = 0;
					flush_col = 0;
				end else begin
					flush_col = d + 1;
				end
			end
			return expected_q.size() - prior_count;
		endfunction

		task report(string msg);
			if (errors < REPORT_CAP)
				$display("[%0t] MISMATCH: %s", $time, msg);
			errors++;
		endtask

		task check_result(sobel_em_out_t got);
			sobel_em_out_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d with nothing pending: %h", checked, got));
				checked++;
				return;
			end
			want = expected_q.pop_front();
			if (got.out_red != want.out_red)
				report($sformatf("result %0d out_red %0d, want %0d",
					checked, got.out_red, want.out_red));
			if (got.out_green != want.out_green)
				report($sformatf("result %0d out_green %0d, want %0d",
					checked, got.out_green, want.out_green));
			if (got.out_blue != want.out_blue)
				report($sformatf("result %0d out_blue %0d, want %0d",
					checked, got.out_blue, want.out_blue));
			if (got.frame_end != want.frame_end)
				report($sformatf("result %0d frame_end %0b, want %0b",
					checked, got.frame_end, want.frame_end));
			checked++;
		endtask
	endclass

	// ------------------------------------------------------------------------
	// DUT and its surroundings
	// ------------------------------------------------------------------------
	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	sobel_em_in_t           in_data;
	logic                   out_valid;
	logic                   out_ready;
	sobel_em_out_t          out_data;

	edge_scoreboard board;
	int             sender_idle_pct;
	int             receiver_stall_pct;
	bit             hold_request;
	int             quiet_cycles;

	sobel_edge_magnitude_rgb dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// 20 ns period
	always #10 clk = ~clk;

	// results are picked up at the rising edge, compared straight away
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(out_data);
	end

	// watchdog: any request, result or register write counts as progress
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: random stalls at the falling edge; a hold-off request parks
	// out_ready low for a fixed stretch counted here, whatever the sender does
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			out_ready = ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers; each starts and ends just after a falling edge
	// ------------------------------------------------------------------------

	// flat areas and hard steps are both needed to hit zero and saturation
	function automatic logic [CHAN_W-1:0] rand_level();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return CHAN_W'($urandom_range(255));
		endcase
	endfunction

	function automatic sobel_em_in_t make_request(logic act, logic [CHAN_W-1:0] r,
		logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
		sobel_em_in_t req;
		req.action   = act;
		req.in_red   = r;
		req.in_green = g;
		req.in_blue  = b;
		return req;
	endfunction

	// offer one request, holding it steady until the block takes it
	task automatic send_request(input sobel_em_in_t req, output int produced);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		produced = board.note_request(req);
		@(negedge clk);
	endtask

	// a run of requests of one kind with random channels; dropped ones don't count
	task automatic send_run(input logic act, input int count, inout int taken);
		int produced;
		repeat (count) begin
			send_request(make_request(act, rand_level(), rand_level(), rand_level()),
				produced);
			if (produced >= 0)
				taken++;
		end
	endtask

	// let the block settle: all results back, then a margin for silent pixels
	task automatic wait_idle();
		in_valid = 1'b0;
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		board.write_register(idx, val);
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// one whole frame under the current settings; noise_pct adds stray drains
	// mid-frame and stray pixels after the last one, both of which are dropped
	task automatic send_frame(input int noise_pct, inout int taken);
		int unsigned pixels;
		pixels = board.frame_cols() * board.frame_rows();
		repeat (pixels) begin
			if ($urandom_range(99) < noise_pct)
				send_run(ACT_DRAIN, 1, taken);
			send_run(ACT_PIXEL, 1, taken);
		end
		if ($urandom_range(99) < noise_pct * 4)
			send_run(ACT_PIXEL, $urandom_range(2, 1), taken);
		send_run(ACT_DRAIN, board.frame_cols(), taken);
	endtask

	task automatic run_random_frame(input bit pressure, inout int taken);
		int unsigned cols, rows;
		if (pressure) begin
			cols = 8;
			rows = 6;
		end else begin
			cols = ($urandom_range(9) < 8) ? $urandom_range(8, 1) : $urandom_range(40, 9);
			rows = $urandom_range(6, 1);
			if ($urandom_range(19) == 0)
				cols = 0;
			if ($urandom_range(19) == 0)
				rows = 0;
		end
		// most frames change shape; some reuse the last one
		if (pressure || $urandom_range(3) != 0) begin
			wait_idle();
			write_register(REG_FRAME_WIDTH, CFG_DATA_W'(cols));
			write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(rows));
		end
		if (pressure)
			hold_request = 1'b1;
		send_frame(6, taken);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int taken;
		int produced;
		int i;
		int phase;

		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_write          = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		in_valid           = 1'b0;
		in_data            = '0;
		out_ready          = 1'b0;
		hold_request       = 1'b0;
		quiet_cycles       = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		taken              = 0;
		board              = new();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed: reset shape, drain before the frame's last pixel is dropped
		send_request(make_request(ACT_DRAIN, 8'hFF, 8'hFF, 8'hFF), produced);

		// 3x3 frame with hard steps: red alternates, green only on the top row,
		// blue flat so only the zero-padded border shows an edge
		wait_idle();
		write_register(REG_FRAME_WIDTH, 16'd3);
		write_register(REG_FRAME_HEIGHT, 16'd3);
		for (i = 0; i < 9; i++)
			send_request(make_request(ACT_PIXEL, (i % 2 != 0) ? 8'hFF : 8'h00,
				(i < 3) ? 8'hFF : 8'h00, 8'hFF), produced);
		// pixel past the frame end is dropped until the drains are done
		send_request(make_request(ACT_PIXEL, 8'hA5, 8'h5A, 8'h3C), produced);
		for (i = 0; i < 3; i++)
			send_request(make_request(ACT_DRAIN, 8'h00, 8'h00, 8'h00), produced);

		// zero width and height both behave as one
		wait_idle();
		write_register(REG_FRAME_WIDTH, 16'd0);
		write_register(REG_FRAME_HEIGHT, 16'd0);
		send_request(make_request(ACT_PIXEL, 8'hFF, 8'h00, 8'hAA), produced);
		send_request(make_request(ACT_DRAIN, 8'h55, 8'hFF, 8'h00), produced);

		// --- shape lowered mid-frame, block idle each time
		// tallest height, 3 rows and 4 pixels of a 6-wide frame...
		wait_idle();
		write_register(REG_FRAME_WIDTH, 16'd6);
		write_register(REG_FRAME_HEIGHT, 16'hFFFF);
		send_run(ACT_PIXEL, 6 * 3 + 4, taken);
		// ...width drops to 4: the next pixel's column is past it and closes the row
		wait_idle();
		write_register(REG_FRAME_WIDTH, 16'd4);
		send_run(ACT_PIXEL, 1 + 4, taken);
		// height drops to the rows already in: frame is over, drains take effect
		wait_idle();
		write_register(REG_FRAME_HEIGHT, 16'd5);
		send_run(ACT_PIXEL, 1, taken);
		send_run(ACT_DRAIN, 2, taken);
		// width drops below the drain column: next drain is the frame's last
		wait_idle();
		write_register(REG_FRAME_WIDTH, 16'd2);
		send_run(ACT_DRAIN, 1, taken);

		// --- random frames under four handshake regimes
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct    = 64;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 64;
				end
				default: begin
					sender_idle_pct    = 23;
					receiver_stall_pct = 23;
				end
			endcase
			taken = 0;
			// first frame of the unthrottled phase runs against a long hold-off
			run_random_frame(phase == 0, taken);
			while (taken < ITEMS_PER_PHASE)
				run_random_frame(1'b0, taken);
		end

		// --- wind down: everything back, then a margin for stray results
		in_valid = 1'b0;
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);

		if (board.errors == 0 && board.expected_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/sobel_em_pkg.sv
hw/rtl/sobel_em_mag.sv
hw/rtl/sobel_edge_magnitude_rgb.sv
verif/sobel_edge_magnitude_rgb_tb.sv
